// ----- hw/rtl/rc4_pixel_stream_cipher_top_assert.svh -----
// Assertion macros shared by the rc4 checker.
`ifndef RC4_PIXEL_STREAM_CIPHER_TOP_ASSERT_SVH
`define RC4_PIXEL_STREAM_CIPHER_TOP_ASSERT_SVH

// same-cycle implication
`define RC4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rc4_pkg.sv -----
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 9;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // request selector codes (tuser)
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_SCHED = 2'd1;
    localparam logic [1:0] FUNC_PIXEL = 2'd2;

    localparam logic [LEN_W-1:0] KEY_LEN_RST = 9'd128;

    typedef struct packed {
        logic              clr;
        logic              wr_en;
        logic [BYTE_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic [BYTE_W-1:0] rd_addr;
    } t_perm_req;

    typedef struct packed {
        logic              wr_en;
        logic [BYTE_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic [BYTE_W-1:0] rd_addr;
    } t_key_req;

endpackage

// ----- hw/rtl/rc4_perm_ram.sv -----
`timescale 1ns / 1ps

module rc4_perm_ram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rc4_pkg::t_perm_req            i_req,
    output logic [rc4_pkg::BYTE_W-1:0]    o_rd_data
);

    logic [rc4_pkg::BYTE_W-1:0] r_mem [256];
    logic [255:0]               r_vld;
    logic [rc4_pkg::BYTE_W-1:0] r_rd_data;
    logic [rc4_pkg::BYTE_W-1:0] r_rd_addr;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
        r_rd_addr <= i_req.rd_addr;
        r_rd_vld  <= r_vld[i_req.rd_addr];
    end

    // entry never written since reset/clear reads as identity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : r_rd_addr;

endmodule

// ----- hw/rtl/rc4_key_ram.sv -----
`timescale 1ns / 1ps

module rc4_key_ram #(
    parameter int KEY_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rc4_pkg::t_key_req             i_req,
    output logic [rc4_pkg::BYTE_W-1:0]    o_rd_data
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    logic [rc4_pkg::BYTE_W-1:0] r_mem [KEY_DEPTH];
    logic [KEY_DEPTH-1:0]       r_vld;
    logic [rc4_pkg::BYTE_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        r_rd_vld  <= r_vld[i_req.rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr[AW-1:0]] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- hw/rtl/rc4_ctrl.sv -----
`timescale 1ns / 1ps

module rc4_ctrl #(
    parameter int KEY_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_vld,
    output logic                              o_in_rdy,
    input  logic [1:0]                        i_func,
    input  logic [rc4_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [rc4_pkg::LEN_W-1:0]         i_key_len,
    output logic                              o_out_vld,
    input  logic                              i_out_rdy,
    output logic [rc4_pkg::OUT_DATA_W-1:0]    o_out_data,
    output rc4_pkg::t_perm_req                o_perm_req,
    input  logic [rc4_pkg::BYTE_W-1:0]        i_perm_rd,
    output rc4_pkg::t_key_req                 o_key_req,
    input  logic [rc4_pkg::BYTE_W-1:0]        i_key_rd
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [rc4_pkg::LEN_W-1:0] DEPTH_L = rc4_pkg::LEN_W'(KEY_DEPTH);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_KS_RD  = 10'b00_0000_0010,
        ST_KS_SUM = 10'b00_0000_0100,
        ST_KS_WN  = 10'b00_0000_1000,
        ST_KS_WJ  = 10'b00_0001_0000,
        ST_PX_RD  = 10'b00_0010_0000,
        ST_PX_SUM = 10'b00_0100_0000,
        ST_PX_WI  = 10'b00_1000_0000,
        ST_PX_WJ  = 10'b01_0000_0000,
        ST_PX_OUT = 10'b10_0000_0000
    } t_state;

    t_state                            r_state, n_state;
    logic [rc4_pkg::BYTE_W-1:0]        r_gi, n_gi;
    logic [rc4_pkg::BYTE_W-1:0]        r_gj, n_gj;
    logic [rc4_pkg::BYTE_W-1:0]        r_sa, n_sa;
    logic [rc4_pkg::BYTE_W-1:0]        r_sb, n_sb;
    logic [rc4_pkg::BYTE_W-1:0]        r_t, n_t;
    logic [rc4_pkg::BYTE_W-1:0]        r_ks, n_ks;
    logic [AW-1:0]                     r_kpos, n_kpos;
    logic [rc4_pkg::OUT_DATA_W-1:0]    r_px, n_px;
    logic                              r_out_vld, n_out_vld;
    logic [rc4_pkg::OUT_DATA_W-1:0]    r_out_data, n_out_data;

    logic [rc4_pkg::BYTE_W-1:0]        w_add_a, w_add_b, w_add_c, w_sum;
    logic [rc4_pkg::LEN_W-1:0]         w_kpos_inc;
    logic                              w_accept;
    logic [rc4_pkg::BYTE_W-1:0]        w_key_idx;

    assign o_in_rdy   = (r_state == ST_IDLE);
    assign w_accept   = i_in_vld && o_in_rdy;
    assign w_key_idx  = i_in_data[7:0];
    assign w_kpos_inc = rc4_pkg::LEN_W'(r_kpos) + 9'd1;

    // shared byte adder: index increment, j update, keystream address
    always_comb begin
        w_add_a = r_gi;
        w_add_b = 8'd1;
        w_add_c = 8'd0;
        unique case (r_state)
            ST_KS_SUM: begin
                w_add_a = r_gj;
                w_add_b = i_perm_rd;
                w_add_c = i_key_rd;
            end
            ST_PX_SUM: begin
                w_add_a = r_gj;
                w_add_b = i_perm_rd;
            end
            ST_PX_WI: begin
                w_add_a = r_sa;
                w_add_b = i_perm_rd;
            end
            default: ;
        endcase
    end

    assign w_sum = w_add_a + w_add_b + w_add_c;

    always_comb begin
        n_state    = r_state;
        n_gi       = r_gi;
        n_gj       = r_gj;
        n_sa       = r_sa;
        n_sb       = r_sb;
        n_t        = r_t;
        n_ks       = r_ks;
        n_kpos     = r_kpos;
        n_px       = r_px;
        n_out_data = r_out_data;
        n_out_vld  = r_out_vld && !i_out_rdy;
        o_perm_req = '0;
        o_key_req  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        rc4_pkg::FUNC_LOAD: begin
                            o_key_req.wr_en   = ({1'b0, w_key_idx} < DEPTH_L);
                            o_key_req.wr_addr = w_key_idx;
                            o_key_req.wr_data = i_in_data[15:8];
                        end
                        rc4_pkg::FUNC_SCHED: begin
                            o_perm_req.clr = 1'b1;
                            n_gi    = '0;
                            n_gj    = '0;
                            n_kpos  = '0;
                            n_state = ST_KS_RD;
                        end
                        rc4_pkg::FUNC_PIXEL: begin
                            n_px    = i_in_data[39:16];
                            n_state = ST_PX_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_KS_RD: begin
                o_perm_req.rd_addr = r_gi;
                o_key_req.rd_addr  = rc4_pkg::BYTE_W'(r_kpos);
                n_state = ST_KS_SUM;
            end
            ST_KS_SUM: begin
                n_sa = i_perm_rd;
                n_gj = w_sum;
                o_perm_req.rd_addr = w_sum;
                n_state = ST_KS_WN;
            end
            ST_KS_WN: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_gi;
                o_perm_req.wr_data = i_perm_rd;
                n_state = ST_KS_WJ;
            end
            ST_KS_WJ: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_gj;
                o_perm_req.wr_data = r_sa;
                n_gi   = w_sum;
                n_kpos = (w_kpos_inc >= i_key_len) ? '0 : w_kpos_inc[AW-1:0];
                if (r_gi == 8'hFF) begin
                    n_gj    = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_KS_RD;
                end
            end
            ST_PX_RD: begin
                n_gi = w_sum;
                o_perm_req.rd_addr = w_sum;
                n_state = ST_PX_SUM;
            end
            ST_PX_SUM: begin
                n_sa = i_perm_rd;
                n_gj = w_sum;
                o_perm_req.rd_addr = w_sum;
                n_state = ST_PX_WI;
            end
            ST_PX_WI: begin
                // S[t] read next to the write of S[i]; fixed up below
                n_sb = i_perm_rd;
                n_t  = w_sum;
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_gi;
                o_perm_req.wr_data = i_perm_rd;
                o_perm_req.rd_addr = w_sum;
                n_state = ST_PX_WJ;
            end
            ST_PX_WJ: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_gj;
                o_perm_req.wr_data = r_sa;
                if (r_t == r_gj) begin
                    n_ks = r_sa;
                end else if (r_t == r_gi) begin
                    n_ks = r_sb;
                end else begin
                    n_ks = i_perm_rd;
                end
                n_state = ST_PX_OUT;
            end
            ST_PX_OUT: begin
                if (!r_out_vld || i_out_rdy) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {r_px[23:8], r_px[7:0] ^ r_ks};
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_gi      <= '0;
            r_gj      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_gi      <= n_gi;
            r_gj      <= n_gj;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_t        <= n_t;
        r_ks       <= n_ks;
        r_kpos     <= n_kpos;
        r_px       <= n_px;
        r_out_data <= n_out_data;
    end

    assign o_out_vld  = r_out_vld;
    assign o_out_data = r_out_data;

endmodule

// ----- hw/rtl/rc4_pixel_stream_cipher_top.sv -----
`timescale 1ns / 1ps

// Channel     Dir  Handshake                     Payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tdata: key_index, key_byte, r, g, b
//                                                tuser: func
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata: out_red, out_green, out_blue
// cfg         in   i_cfg_wr_en                   key_len (9 bits)
//
// Key load: direct write. Key schedule (i = 0..255) and pixel: read, sum, write
// S[i], write S[j], pixel then output; set by the one-read, one-write perm RAM,
// registered read (one access of each kind per cycle), one shared byte adder.
// Reset is synchronous, active low; permutation and key store return to
// identity/zero at once through per-entry valid flops, no clearing pass.
// A finished pixel waits in the output register while the next request is
// taken; a second pixel holds in its last step until the output is free.

module rc4_pixel_stream_cipher_top #(
    parameter int KEY_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] key_index, [15:8] key_byte, [23:16] in_red, [31:24] in_green,
    // [39:32] in_blue
    input  logic [rc4_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [rc4_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [rc4_pkg::LEN_W-1:0]         i_cfg_wr_data
);

    localparam logic [rc4_pkg::LEN_W-1:0] DEPTH_L = rc4_pkg::LEN_W'(KEY_DEPTH);

    logic [rc4_pkg::LEN_W-1:0]  r_key_len;
    logic [rc4_pkg::LEN_W-1:0]  w_len_eff;
    rc4_pkg::t_perm_req         w_perm_req;
    rc4_pkg::t_key_req          w_key_req;
    logic [rc4_pkg::BYTE_W-1:0] w_perm_rd;
    logic [rc4_pkg::BYTE_W-1:0] w_key_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= rc4_pkg::KEY_LEN_RST;
        end else if (i_cfg_wr_en) begin
            r_key_len <= i_cfg_wr_data;
        end
    end

    // clamp to 1..KEY_DEPTH
    always_comb begin
        if (r_key_len == '0) begin
            w_len_eff = 9'd1;
        end else if (r_key_len > DEPTH_L) begin
            w_len_eff = DEPTH_L;
        end else begin
            w_len_eff = r_key_len;
        end
    end

    rc4_ctrl #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_vld   (s_axis_tvalid),
        .o_in_rdy   (s_axis_tready),
        .i_func     (s_axis_tuser),
        .i_in_data  (s_axis_tdata),
        .i_key_len  (w_len_eff),
        .o_out_vld  (m_axis_tvalid),
        .i_out_rdy  (m_axis_tready),
        .o_out_data (m_axis_tdata),
        .o_perm_req (w_perm_req),
        .i_perm_rd  (w_perm_rd),
        .o_key_req  (w_key_req),
        .i_key_rd   (w_key_rd)
    );

    rc4_perm_ram u_perm_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_perm_req),
        .o_rd_data (w_perm_rd)
    );

    rc4_key_ram #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_key_req),
        .o_rd_data (w_key_rd)
    );

endmodule

// ----- hw/rtl/rc4_chk.sv -----
`timescale 1ns / 1ps

`include "rc4_pixel_stream_cipher_top_assert.svh"

module rc4_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [1:0]                        s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [rc4_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    logic w_acc;
    logic w_quick;

    assign w_acc   = s_axis_tvalid && s_axis_tready;
    // key loads and unused codes finish in the accepting cycle
    assign w_quick = (s_axis_tuser != rc4_pkg::FUNC_SCHED) &&
                     (s_axis_tuser != rc4_pkg::FUNC_PIXEL);

    `RC4_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed under stall")
    `RC4_ASSERT_NEXT(a_px_busy, w_acc && (s_axis_tuser == rc4_pkg::FUNC_PIXEL), !s_axis_tready, "ready right after pixel request")
    `RC4_ASSERT_NEXT(a_ks_busy, w_acc && (s_axis_tuser == rc4_pkg::FUNC_SCHED), !s_axis_tready, "ready right after key schedule request")
    `RC4_ASSERT_NEXT(a_quick_rdy, w_acc && w_quick, s_axis_tready, "not ready after key load")

endmodule

bind rc4_pixel_stream_cipher_top rc4_chk u_rc4_chk (.*);
